// ----- rtl/srfc8_pkg.sv -----
// shared constants and the crc-8 byte update of the serial frame receiver
package srfc8_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'h55;
    localparam logic [7:0] HDR_SECOND  = 8'hAA;
    localparam logic [7:0] CRC_POLY    = 8'h8C;

    localparam int         FLAG_W        = 31;
    localparam int         WORD_W        = 32;
    localparam int         BYTE_W        = 8;
    localparam int         PAYLOAD_BYTES_DEF = 16;
    localparam int         WORDS_OUT     = 4;

    localparam logic [FLAG_W-1:0] MAX_FLAG_RST = 31'd100;
    localparam logic [WORD_W-1:0] SIGN_FLIP    = 32'h8000_0000;

    // reflected crc-8, lsb first, eight shifts per byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    localparam logic [7:0] CRC_AFTER_HDR = crc8_byte(crc8_byte(8'h00, HDR_FIRST), HDR_SECOND);

endpackage

// ----- rtl/srfc8_if.sv -----
// valid/ready channels for received bytes and decoded frame results
interface srfc8_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srfc8_res_if;
    logic                             valid;
    logic                             ready;
    logic [srfc8_pkg::WORD_W-1:0]     x_word;
    logic [srfc8_pkg::WORD_W-1:0]     y_word;
    logic [srfc8_pkg::WORD_W-1:0]     w_word;
    logic [srfc8_pkg::FLAG_W-1:0]     flag_value;
    logic                             crc_ok;

    modport source (output valid, output x_word, output y_word, output w_word,
                    output flag_value, output crc_ok, input ready);
    modport sink   (input valid, input x_word, input y_word, input w_word,
                    input flag_value, input crc_ok, output ready);
endinterface

// ----- rtl/serial_frame_receiver_crc8_unit.sv -----
// a result follows the second trailer byte, which waits until the prior result is taken;
// throughput: one byte per cycle otherwise; after each frame the byte input stalls while
// the four payload words are read back through the single read port of the payload ram
// reset: asynchronous, active low; clears the framer, the byte valid bits (store reads
// as zero), the last valid flag, max_flag to 100 and the result slot; no clearing pass
module serial_frame_receiver_crc8_unit #(
    parameter int PAYLOAD_BYTES = srfc8_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srfc8_pkg::FLAG_W-1:0]  cfg_wdata,
    srfc8_rx_if.sink                      rx,
    srfc8_res_if.source                   res
);
    import srfc8_pkg::*;

    localparam int ROWS  = (PAYLOAD_BYTES + 3) / 4;
    localparam int ROW_W = $clog2(ROWS);
    localparam int IDX_W = $clog2(PAYLOAD_BYTES);
    localparam logic [7:0] PB8 = 8'(PAYLOAD_BYTES);

    typedef enum logic [1:0] {PH_LEN, PH_PAYLOAD, PH_CRC, PH_TRAILER} phase_t;

    // payload ram: 32-bit rows with byte lanes
    logic [WORD_W-1:0] mem [ROWS];

    logic                     in_frame_reg, in_frame_next;
    logic [7:0]               prev_byte_reg, prev_byte_next;
    phase_t                   phase_reg, phase_next;
    logic [7:0]               frame_len_reg, frame_len_next;
    logic [7:0]               pay_cnt_reg, pay_cnt_next;
    logic                     trailer_seen_reg, trailer_seen_next;
    logic [7:0]               crc_reg, crc_next;
    logic [7:0]               rx_crc_reg, rx_crc_next;
    logic [FLAG_W-1:0]        last_flag_reg, last_flag_next;
    logic [FLAG_W-1:0]        max_flag_reg, max_flag_next;
    logic [PAYLOAD_BYTES-1:0] byte_vld_reg, byte_vld_next;
    logic                     drain_reg, drain_next;
    logic [2:0]               issue_cnt_reg, issue_cnt_next;
    logic                     ret_vld_reg, ret_vld_next;
    logic [1:0]               ret_row_reg, ret_row_next;
    logic                     crc_ok_reg, crc_ok_next;
    logic [WORD_W-1:0]        x_asm_reg, x_asm_next;
    logic [WORD_W-1:0]        y_asm_reg, y_asm_next;
    logic [WORD_W-1:0]        w_asm_reg, w_asm_next;
    logic                     out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]        out_x_reg, out_x_next;
    logic [WORD_W-1:0]        out_y_reg, out_y_next;
    logic [WORD_W-1:0]        out_w_reg, out_w_next;
    logic [FLAG_W-1:0]        out_flag_reg, out_flag_next;
    logic                     out_crc_ok_reg, out_crc_ok_next;

    logic [WORD_W-1:0]        rd_data_reg;
    logic                     rd_en;
    logic [ROW_W-1:0]         rd_row;
    logic                     mem_we;
    logic [ROW_W-1:0]         wr_row;
    logic [1:0]               wr_lane;
    logic                     acc;
    logic                     frame_done;
    logic                     at_last;
    logic [7:0]               cnt_inc;
    logic [7:0]               needed;
    logic [3:0]               row_vld;
    logic [WORD_W-1:0]        ret_word;

    assign at_last  = in_frame_reg && (phase_reg == PH_TRAILER) && trailer_seen_reg;
    assign rx.ready = !drain_reg && !(at_last && out_valid_reg);
    assign acc      = rx.valid && rx.ready;

    assign cnt_inc  = pay_cnt_reg + 8'd1;
    assign needed   = (frame_len_reg <= 8'd1) ? 8'd1 : frame_len_reg - 8'd1;

    assign mem_we   = acc && in_frame_reg && (phase_reg == PH_PAYLOAD) && (pay_cnt_reg < PB8);
    assign wr_row   = pay_cnt_reg[ROW_W+1:2];
    assign wr_lane  = pay_cnt_reg[1:0];

    assign rd_en    = drain_reg && (issue_cnt_reg < 3'd4);
    assign rd_row   = ROW_W'(issue_cnt_reg[1:0]);

    assign frame_done = acc && at_last;

    // bytes never written since reset read as zero
    assign row_vld = 4'(byte_vld_reg[WORDS_OUT*4-1:0] >> {ret_row_reg, 2'b00});
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            ret_word[k*8 +: 8] = row_vld[k] ? rd_data_reg[k*8 +: 8] : 8'h00;
    end

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        prev_byte_next    = prev_byte_reg;
        phase_next        = phase_reg;
        frame_len_next    = frame_len_reg;
        pay_cnt_next      = pay_cnt_reg;
        trailer_seen_next = trailer_seen_reg;
        crc_next          = crc_reg;
        rx_crc_next       = rx_crc_reg;
        last_flag_next    = last_flag_reg;
        max_flag_next     = cfg_we ? cfg_wdata : max_flag_reg;
        byte_vld_next     = byte_vld_reg;
        drain_next        = drain_reg;
        issue_cnt_next    = issue_cnt_reg;
        ret_vld_next      = rd_en;
        ret_row_next      = issue_cnt_reg[1:0];
        crc_ok_next       = crc_ok_reg;
        x_asm_next        = x_asm_reg;
        y_asm_next        = y_asm_reg;
        w_asm_next        = w_asm_reg;
        out_valid_next    = out_valid_reg && !res.ready;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_w_next        = out_w_reg;
        out_flag_next     = out_flag_reg;
        out_crc_ok_next   = out_crc_ok_reg;

        if (mem_we)
            byte_vld_next[pay_cnt_reg[IDX_W-1:0]] = 1'b1;

        if (acc)
        begin
            if (!in_frame_reg)
            begin
                if (rx.rx_byte == HDR_SECOND)
                begin
                    if (prev_byte_reg == HDR_FIRST)
                    begin
                        in_frame_next     = 1'b1;
                        phase_next        = PH_LEN;
                        pay_cnt_next      = 8'd0;
                        trailer_seen_next = 1'b0;
                        crc_next          = CRC_AFTER_HDR;
                    end
                end
                else
                begin
                    prev_byte_next = rx.rx_byte;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        frame_len_next = rx.rx_byte;
                        crc_next       = crc8_byte(crc_reg, rx.rx_byte);
                        pay_cnt_next   = 8'd0;
                        phase_next     = PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        crc_next = crc8_byte(crc_reg, rx.rx_byte);
                        if (cnt_inc >= needed)
                        begin
                            pay_cnt_next = 8'd0;
                            phase_next   = PH_CRC;
                        end
                        else
                        begin
                            pay_cnt_next = cnt_inc;
                        end
                    end
                    PH_CRC:
                    begin
                        rx_crc_next = rx.rx_byte;
                        crc_next    = crc8_byte(crc_reg, 8'h00);
                        phase_next  = PH_TRAILER;
                    end
                    PH_TRAILER:
                    begin
                        if (!trailer_seen_reg)
                        begin
                            trailer_seen_next = 1'b1;
                        end
                        else
                        begin
                            crc_ok_next       = (crc_reg == rx_crc_reg);
                            in_frame_next     = 1'b0;
                            prev_byte_next    = 8'h00;
                            phase_next        = PH_LEN;
                            frame_len_next    = 8'h00;
                            pay_cnt_next      = 8'd0;
                            trailer_seen_next = 1'b0;
                            crc_next          = 8'h00;
                            drain_next        = 1'b1;
                            issue_cnt_next    = 3'd0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LEN;
                    end
                endcase
            end
        end

        if (rd_en)
            issue_cnt_next = issue_cnt_reg + 3'd1;

        // gather the four words as they come back from the ram
        if (ret_vld_reg)
        begin
            case (ret_row_reg)
                2'd0: x_asm_next = ret_word;
                2'd1: y_asm_next = ret_word;
                2'd2: w_asm_next = ret_word;
                default:
                begin
                    if (!ret_word[WORD_W-1] && (ret_word[FLAG_W-1:0] <= max_flag_reg))
                        last_flag_next = ret_word[FLAG_W-1:0];
                    out_valid_next  = 1'b1;
                    out_x_next      = x_asm_reg ^ SIGN_FLIP;
                    out_y_next      = y_asm_reg ^ SIGN_FLIP;
                    out_w_next      = w_asm_reg;
                    out_flag_next   = last_flag_next;
                    out_crc_ok_next = crc_ok_reg;
                    drain_next      = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_row][wr_lane*8 +: 8] <= rx.rx_byte;
        if (rd_en)
            rd_data_reg <= mem[rd_row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            prev_byte_reg    <= 8'h00;
            phase_reg        <= PH_LEN;
            frame_len_reg    <= 8'h00;
            pay_cnt_reg      <= 8'd0;
            trailer_seen_reg <= 1'b0;
            crc_reg          <= 8'h00;
            rx_crc_reg       <= 8'h00;
            last_flag_reg    <= '0;
            max_flag_reg     <= MAX_FLAG_RST;
            byte_vld_reg     <= '0;
            drain_reg        <= 1'b0;
            issue_cnt_reg    <= 3'd0;
            ret_vld_reg      <= 1'b0;
            ret_row_reg      <= 2'd0;
            crc_ok_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            in_frame_reg     <= in_frame_next;
            prev_byte_reg    <= prev_byte_next;
            phase_reg        <= phase_next;
            frame_len_reg    <= frame_len_next;
            pay_cnt_reg      <= pay_cnt_next;
            trailer_seen_reg <= trailer_seen_next;
            crc_reg          <= crc_next;
            rx_crc_reg       <= rx_crc_next;
            last_flag_reg    <= last_flag_next;
            max_flag_reg     <= max_flag_next;
            byte_vld_reg     <= byte_vld_next;
            drain_reg        <= drain_next;
            issue_cnt_reg    <= issue_cnt_next;
            ret_vld_reg      <= ret_vld_next;
            ret_row_reg      <= ret_row_next;
            crc_ok_reg       <= crc_ok_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_asm_reg      <= x_asm_next;
        y_asm_reg      <= y_asm_next;
        w_asm_reg      <= w_asm_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_w_reg      <= out_w_next;
        out_flag_reg   <= out_flag_next;
        out_crc_ok_reg <= out_crc_ok_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.x_word     = out_x_reg;
    assign res.y_word     = out_y_reg;
    assign res.w_word     = out_w_reg;
    assign res.flag_value = out_flag_reg;
    assign res.crc_ok     = out_crc_ok_reg;

    // the read-back is the interlock: no ram write can overlap it
    a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !drain_reg)
        else $error("payload ram written during read-back");

    a_return_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ret_vld_reg |-> drain_reg)
        else $error("ram data returned outside read-back");

    a_slot_free_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (ret_vld_reg && ret_row_reg == 2'd3) |-> !out_valid_reg)
        else $error("result slot overwritten before it was taken");

    a_done_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (drain_reg && issue_cnt_reg == 3'd0))
        else $error("frame end did not start read-back");

endmodule

// ----- dv/serial_frame_receiver_crc8_unit_test.sv -----
// self-checking testbench for the serial frame receiver with crc-8 check
`timescale 1ns / 1ps

module serial_frame_receiver_crc8_unit_test;
    import srfc8_pkg::*;

    localparam int          STORE_BYTES   = PAYLOAD_BYTES_DEF;
    localparam int          SETTLE_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef enum logic [1:0] {PH_LENGTH, PH_PAYLOAD, PH_CRC, PH_TRAILER} deframe_phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] x_word;
        logic [WORD_W-1:0] y_word;
        logic [WORD_W-1:0] w_word;
        logic [FLAG_W-1:0] flag_value;
        logic              crc_ok;
    } frame_result_t;

    typedef struct packed {
        logic [1:0]    lead_n;
        logic [15:0]   lead;
        logic [7:0]    len;
        logic [7:0]    fill;
        logic          ramp;
        logic          crc_good;
        logic          set_flag;
        logic [31:0]   flag_word;
        logic          known;
        frame_result_t typed;
    } frame_row_t;

    localparam int DIRECTED_N = 15;

    // lead bytes go out low byte first; typed crc_ok is ignored
    localparam frame_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{2'd0, 16'h0000, 8'd0, 8'h00, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1,
          '{32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 31'd0, 1'b0}},
        '{2'd0, 16'h0000, 8'd1, 8'h7F, 1'b0, 1'b0, 1'b0, 32'h0, 1'b1,
          '{32'h8000_007F, 32'h8000_0000, 32'h0000_0000, 31'd0, 1'b0}},
        '{2'd0, 16'h0000, 8'd17, 8'hFF, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1,
          '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'd0, 1'b0}},
        '{2'd0, 16'h0000, 8'd17, 8'h00, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1,
          '{32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 31'd0, 1'b0}},
        '{2'd2, 16'h55AA, 8'd17, 8'h01, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0, '0},
        '{2'd2, 16'h0055, 8'd3, 8'h80, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, '0},
        '{2'd0, 16'h0000, 8'd255, 8'h00, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0, '0},
        '{2'd0, 16'h0000, 8'd17, 8'h00, 1'b0, 1'b1, 1'b1, 32'd100, 1'b1,
          '{32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 31'd100, 1'b0}},
        '{2'd0, 16'h0000, 8'd17, 8'h00, 1'b0, 1'b1, 1'b1, 32'd101, 1'b1,
          '{32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 31'd100, 1'b0}},
        '{2'd0, 16'h0000, 8'd17, 8'h00, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 1'b1,
          '{32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 31'd100, 1'b0}},
        '{2'd0, 16'h0000, 8'd17, 8'h00, 1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1,
          '{32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 31'd100, 1'b0}},
        '{2'd0, 16'h0000, 8'd2, 8'h5A, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, '0},
        '{2'd2, 16'hAAAA, 8'd16, 8'hF0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, '0},
        '{2'd0, 16'h0000, 8'd18, 8'h55, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, '0},
        '{2'd1, 16'h0055, 8'hAA, 8'hAA, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, '0}
    };

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [FLAG_W-1:0] cfg_wdata  = '0;
    logic              byte_valid = 1'b0;
    logic [7:0]        byte_data  = 8'h00;
    logic              sink_ready = 1'b0;

    int unsigned src_gap_pct  = 29;
    int unsigned sink_gap_pct = 61;
    int unsigned cycle_count  = 0;
    int unsigned mismatches   = 0;
    int unsigned frames_checked = 0;
    int unsigned bad_crc_frames = 0;
    int unsigned flag_fallbacks = 0;
    int unsigned bytes_sent     = 0;

    // deframer state as the block should hold it
    logic              framing      = 1'b0;
    logic [7:0]        hunt_prev    = 8'h00;
    deframe_phase_t    fphase       = PH_LENGTH;
    logic [7:0]        len_byte     = 8'h00;
    int unsigned       pay_count    = 0;
    logic              trailer_half = 1'b0;
    logic [7:0]        pay_mem [STORE_BYTES];
    logic [7:0]        crc_acc      = 8'h00;
    logic [7:0]        crc_rx       = 8'h00;
    logic [31:0]       kept_flag    = 32'h0;
    logic [FLAG_W-1:0] flag_limit   = MAX_FLAG_RST;
    frame_result_t     last_prediction;
    frame_result_t     pending_frames [$];

    srfc8_rx_if  rx_ch ();
    srfc8_res_if res_ch ();

    assign rx_ch.valid   = byte_valid;
    assign rx_ch.rx_byte = byte_data;
    assign res_ch.ready  = sink_ready;

    serial_frame_receiver_crc8_unit #(
        .PAYLOAD_BYTES (STORE_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        sink_ready <= ($urandom_range(99) >= sink_gap_pct);

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] c;
        c = acc ^ din;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // a length of 0 or 1 still carries one payload byte
    function automatic int unsigned body_len(input logic [7:0] len);
        return (len <= 8'd1) ? 1 : int'(len) - 1;
    endfunction

    function automatic logic [31:0] mem_word(input int base);
        return {pay_mem[base+3], pay_mem[base+2], pay_mem[base+1], pay_mem[base]};
    endfunction

    function automatic string show(input frame_result_t r);
        return $sformatf("x=%h y=%h w=%h flag=%h crc_ok=%b",
                         r.x_word, r.y_word, r.w_word, r.flag_value, r.crc_ok);
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic check_frame(input string src, input frame_result_t want,
                               input frame_result_t got);
        if (got !== want)
            note_failure($sformatf("%s mismatch: expected %s, got %s", src, show(want),
                                   show(got)));
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [31:0]   fw;
        frame_result_t r;
        if (!framing)
        begin
            // 0xaa never replaces the remembered byte
            if (b == HDR_SECOND)
            begin
                if (hunt_prev == HDR_FIRST)
                begin
                    framing      = 1'b1;
                    fphase       = PH_LENGTH;
                    pay_count    = 0;
                    trailer_half = 1'b0;
                    crc_acc      = crc8_step(crc8_step(8'h00, HDR_FIRST), HDR_SECOND);
                end
            end
            else
                hunt_prev = b;
            return;
        end
        case (fphase)
            PH_LENGTH:
            begin
                len_byte  = b;
                crc_acc   = crc8_step(crc_acc, b);
                pay_count = 0;
                fphase    = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                // bytes past the store still count towards the crc
                if (pay_count < STORE_BYTES)
                    pay_mem[pay_count] = b;
                crc_acc = crc8_step(crc_acc, b);
                pay_count++;
                if (pay_count >= body_len(len_byte))
                begin
                    pay_count = 0;
                    fphase    = PH_CRC;
                end
            end
            PH_CRC:
            begin
                crc_rx  = b;
                crc_acc = crc8_step(crc_acc, 8'h00);
                fphase  = PH_TRAILER;
            end
            default:
            begin
                if (!trailer_half)
                    trailer_half = 1'b1;
                else
                begin
                    r.x_word = mem_word(0) ^ SIGN_FLIP;
                    r.y_word = mem_word(4) ^ SIGN_FLIP;
                    r.w_word = mem_word(8);
                    fw = mem_word(12);
                    if (!fw[31] && fw[FLAG_W-1:0] <= flag_limit)
                        kept_flag = fw;
                    else
                        flag_fallbacks++;
                    r.flag_value = kept_flag[FLAG_W-1:0];
                    r.crc_ok     = (crc_acc == crc_rx);
                    if (!r.crc_ok)
                        bad_crc_frames++;
                    pending_frames.push_back(r);
                    last_prediction = r;
                    framing      = 1'b0;
                    hunt_prev    = 8'h00;
                    fphase       = PH_LENGTH;
                    len_byte     = 8'h00;
                    pay_count    = 0;
                    trailer_half = 1'b0;
                    crc_acc      = 8'h00;
                end
            end
        endcase
    endtask

    // called at a rising edge; returns at the edge where the request was taken
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_gap_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= b;
        @(negedge clk);
        while (!rx_ch.ready)
            @(negedge clk);
        absorb_byte(b);
        bytes_sent++;
        @(posedge clk);
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] body [$],
                              input bit crc_good, input bit set_flag,
                              input logic [31:0] flag_word);
        logic [7:0] crc;
        if (set_flag && body.size() >= 16)
            for (int i = 0; i < 4; i++)
                body[12+i] = flag_word[8*i +: 8];
        crc = crc8_step(crc8_step(crc8_step(8'h00, HDR_FIRST), HDR_SECOND), len);
        foreach (body[i])
            crc = crc8_step(crc, body[i]);
        crc = crc8_step(crc, 8'h00);
        if (!crc_good)
            crc = crc ^ 8'($urandom_range(1, 255));
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        push_byte(len);
        foreach (body[i])
            push_byte(body[i]);
        push_byte(crc);
        push_byte(8'($urandom));
        push_byte(8'($urandom));
    endtask

    // lower the request, let every frame come out and the framer settle
    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_flag_limit(input logic [FLAG_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        flag_limit = v;
    endtask

    function automatic logic [31:0] pick_flag();
        case ($urandom_range(3))
            0:       return $urandom_range(0, flag_limit);
            1:       return {1'b0, flag_limit};
            2:       return {1'b0, flag_limit} + 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_frames(input int unsigned byte_budget);
        int unsigned stop_at;
        int unsigned n_noise;
        int unsigned pick;
        logic [7:0]  noise_byte;
        logic [7:0]  len;
        logic [7:0]  body [$];
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at)
        begin
            n_noise = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
            repeat (n_noise)
            begin
                case ($urandom_range(3))
                    0:       noise_byte = HDR_FIRST;
                    1:       noise_byte = HDR_SECOND;
                    default: noise_byte = 8'($urandom);
                endcase
                // keep the noise from opening a frame of its own
                if (hunt_prev == HDR_FIRST && noise_byte == HDR_SECOND)
                    noise_byte = 8'h00;
                push_byte(noise_byte);
            end
            pick = $urandom_range(99);
            if (pick < 70)
                len = 8'($urandom_range(0, 20));
            else if (pick < 95)
                len = 8'd17;
            else
                len = 8'($urandom_range(21, 255));
            body = {};
            repeat (body_len(len))
                body.push_back(8'($urandom));
            send_frame(len, body, $urandom_range(3) != 0, $urandom_range(3) != 0, pick_flag());
        end
    endtask

    always @(negedge clk)
    begin : result_monitor
        frame_result_t got;
        frame_result_t want;
        if (rst_n && res_ch.valid && sink_ready)
        begin
            got = {res_ch.x_word, res_ch.y_word, res_ch.w_word, res_ch.flag_value,
                   res_ch.crc_ok};
            if (pending_frames.size() == 0)
                note_failure($sformatf("unexpected result %s", show(got)));
            else
            begin
                want = pending_frames.pop_front();
                check_frame("result", want, got);
                frames_checked++;
            end
        end
    end

    initial
    begin : stimulus
        frame_row_t    row;
        frame_result_t typed;
        logic [7:0]    body [$];
        foreach (pay_mem[i])
            pay_mem[i] = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under the reset limit of 100
        for (int r = 0; r < DIRECTED_N; r++)
        begin
            row = DIRECTED_ROWS[r];
            for (int i = 0; i < int'(row.lead_n); i++)
                push_byte(row.lead[8*i +: 8]);
            body = {};
            for (int i = 0; i < int'(body_len(row.len)); i++)
                body.push_back(row.ramp ? 8'(row.fill + i) : row.fill);
            send_frame(row.len, body, row.crc_good, row.set_flag, row.flag_word);
            if (row.known)
            begin
                typed        = row.typed;
                typed.crc_ok = last_prediction.crc_ok;
                check_frame($sformatf("table row %0d", r), typed, last_prediction);
            end
        end

        set_flag_limit(31'h7FFF_FFFF);
        random_frames(410);

        src_gap_pct  = 61;
        sink_gap_pct = 29;
        set_flag_limit(31'd0);
        random_frames(410);

        src_gap_pct  = 0;
        sink_gap_pct = 0;
        set_flag_limit(31'($urandom_range(1, 5000)));
        random_frames(205);
        set_flag_limit(MAX_FLAG_RST);
        random_frames(205);

        wait_drained();
        $display("%0d frames checked from %0d bytes, %0d with a bad crc, %0d flag fallbacks",
                 frames_checked, bytes_sent, bad_crc_frames, flag_fallbacks);
        $display("flag limit swept over reset value, max, zero and a mid value; three gap mixes");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/srfc8_pkg.sv
rtl/srfc8_if.sv
rtl/serial_frame_receiver_crc8_unit.sv
dv/serial_frame_receiver_crc8_unit_test.sv
